/* hdl/crpn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpn_pkg: shared types and constants
// Operation codes, widths and status codes of the complex RPN evaluator.
// ----------------------------------------------------------------------------
package crpn_pkg;

  localparam int STACK_DEPTH   = 16;
  localparam int FRACTION_BITS = 16;
  localparam int PTR_W         = $clog2(STACK_DEPTH);
  localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
  localparam int CFG_IDX_W     = 1;
  // Quotient magnitude limit before the fraction steps.
  localparam int QLIM_W        = 31 - FRACTION_BITS;

  typedef enum logic [3:0] {
    OP_PUSHC = 4'd0,
    OP_PUSHZ = 4'd1,
    OP_ADD   = 4'd2,
    OP_SUB   = 4'd3,
    OP_MUL   = 4'd4,
    OP_DIV   = 4'd5,
    OP_DUP   = 4'd6,
    OP_DROP  = 4'd7,
    OP_CONJ  = 4'd8,
    OP_NEG   = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_Z_REAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_Z_IMAG = 1'b1;

  // Divider request and response between the sequencer and the divider.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [31:0] quo;
  } div_rsp_t;

endpackage

/* hdl/crpn_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpn channel interfaces
// Valid/ready channels for tokens, results and configuration writes.
// ----------------------------------------------------------------------------
interface crpn_tok_if;
  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  logic [31:0] const_real;
  logic [31:0] const_imag;
  logic        last_token;
  modport source (output valid, operation, const_real, const_imag, last_token, input ready);
  modport sink   (input valid, operation, const_real, const_imag, last_token, output ready);
endinterface

interface crpn_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_real;
  logic [31:0] value_imag;
  logic [1:0]  status;
  modport source (output valid, value_real, value_imag, status, input ready);
  modport sink   (input valid, value_real, value_imag, status, output ready);
endinterface

interface crpn_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/crpn_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpn_div: restoring magnitude divider
// Unsigned 64 by 64 bit division, one quotient bit per cycle; reports
// whether the integer part overflows and the truncated fixed-point result.
// ----------------------------------------------------------------------------
module crpn_div (
  input  logic                clk,
  input  logic                rst_n,
  input  crpn_pkg::div_req_t  req,
  output crpn_pkg::div_rsp_t  rsp
);

  localparam int STEPS = 64 + crpn_pkg::FRACTION_BITS;
  localparam int SC_W  = $clog2(STEPS + 1);

  logic [63:0]     den_r;
  logic [63:0]     num_r, num_nxt;
  logic [64:0]     rem_r, rem_nxt;
  logic [63:0]     quo_r, quo_nxt;
  logic [SC_W-1:0] cnt_r;
  logic            busy_r, done_r;
  logic            ovf_r;
  logic [64:0]     trial;

  // One shift-subtract step over the numerator bits then the fraction zeros.
  always_comb begin
    trial   = {rem_r[63:0], num_r[63]};
    num_nxt = {num_r[62:0], 1'b0};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      quo_nxt = {quo_r[62:0], 1'b1};
    end else begin
      rem_nxt = trial;
      quo_nxt = {quo_r[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SC_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Every quotient bit passes bit 31 on its way up, so a sticky copy of that
  // bit catches quotients of 2^31 or more even once they leave the register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      den_r <= req.den;
      num_r <= req.num;
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      ovf_r <= ovf_r | quo_r[31];
    end
  end

  // Full quotient holds FRACTION_BITS fraction bits; its integer part must
  // stay below 2^(31-FRACTION_BITS).
  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r | quo_r[31];
  assign rsp.quo  = quo_r[31:0];

endmodule

/* hdl/crpn_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpn_core: token sequencer with shared multiplier
// Holds the operand stack and runs each token through a short sequence of
// steps on one 32x32 multiplier and the shared divider.
// ----------------------------------------------------------------------------
module crpn_core (
  input  logic               clk,
  input  logic               rst_n,
  crpn_tok_if.sink           tok,
  crpn_res_if.source         res,
  crpn_cfg_if.sink           cfg,
  output crpn_pkg::div_req_t dreq,
  input  crpn_pkg::div_rsp_t drsp
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_READ  = 10'b0000000010,
    S_EXEC  = 10'b0000000100,
    S_MUL   = 10'b0000001000,
    S_DIVS  = 10'b0000010000,
    S_DIVW  = 10'b0000100000,
    S_WRITE = 10'b0001000000,
    S_FIN   = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_RDTOP = 10'b1000000000
  } state_t;

  state_t state_r;

  // Operand stack memory, one row per complex entry.
  logic [63:0] mem [crpn_pkg::STACK_DEPTH];
  logic [63:0] rd_a_r, rd_b_r;
  logic [crpn_pkg::PTR_W-1:0] rd_a_addr, rd_b_addr, wr_addr_r;
  logic [63:0] wr_data_r;
  logic        wr_en;

  logic [crpn_pkg::CNT_W-1:0] cnt_r;
  logic [1:0]  err_r;
  logic [31:0] zr_r, zi_r;
  crpn_pkg::op_t op_r;
  logic [31:0] cr_r, ci_r;
  logic        last_r;

  // Product accumulator and multiplier step.
  logic [2:0]          mstep_r;
  logic signed [63:0]  p_r;
  logic signed [64:0]  acc0_r, acc1_r;
  logic signed [64:0]  den_r;
  logic                dsel_r;
  logic [31:0]         res_re_r;
  logic signed [31:0]  ma, mb;

  logic [31:0] o_re_r, o_im_r;
  logic [1:0]  o_st_r;
  logic        o_v_r;

  assign tok.ready = (state_r == S_IDLE);
  assign cfg.ready = 1'b1;
  assign res.valid = o_v_r;
  assign res.value_real = o_re_r;
  assign res.value_imag = o_im_r;
  assign res.status = o_st_r;

  // Sign helpers.
  function automatic logic [31:0] sat65(input logic signed [64:0] v);
    if (v > 65'sd2147483647) return 32'h7fffffff;
    if (v < -65'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] negsat(input logic [31:0] v);
    if (v == 32'h80000000) return 32'h7fffffff;
    return 32'(-v);
  endfunction

  // Multiply: shift right arithmetic (floor) then saturate.
  function automatic logic [31:0] mulfix(input logic signed [64:0] v);
    logic signed [64:0] s;
    s = v >>> crpn_pkg::FRACTION_BITS;
    return sat65(s);
  endfunction

  // Operand selection for each multiplier step.
  always_comb begin
    ma = '0; mb = '0;
    unique case (mstep_r)
      3'd0: begin ma = rd_a_r[63:32]; mb = rd_b_r[63:32]; end // ar*br
      3'd1: begin ma = rd_a_r[31:0];  mb = rd_b_r[31:0];  end // ai*bi
      3'd2: begin ma = rd_a_r[63:32]; mb = rd_b_r[31:0];  end // ar*bi
      3'd3: begin ma = rd_a_r[31:0];  mb = rd_b_r[63:32]; end // ai*br
      3'd4: begin ma = rd_b_r[63:32]; mb = rd_b_r[63:32]; end // br*br
      3'd5: begin ma = rd_b_r[31:0];  mb = rd_b_r[31:0];  end // bi*bi
      default: begin ma = '0; mb = '0; end
    endcase
  end

  logic [crpn_pkg::PTR_W-1:0] top_idx;
  assign top_idx = crpn_pkg::PTR_W'(cnt_r - 1'b1);
  assign rd_b_addr = top_idx;
  assign rd_a_addr = crpn_pkg::PTR_W'(cnt_r - 2'd2);

  // The operands are captured in S_READ, and again in S_RDTOP for a last token, and held while the token executes.
  always_ff @(posedge clk) begin
    if (state_r == S_READ || state_r == S_RDTOP) begin
      rd_b_r <= mem[rd_b_addr];
      rd_a_r <= mem[rd_a_addr];
    end
    if (wr_en) mem[wr_addr_r] <= wr_data_r;
  end
  assign wr_en = (state_r == S_WRITE);

  // Divider request: numerator magnitude of the first or second part.
  logic signed [64:0] dnum;
  logic               dneg;
  assign dnum = dsel_r ? acc1_r : acc0_r;
  assign dneg = dnum[64];
  assign dreq.start = (state_r == S_DIVS);
  assign dreq.num   = dneg ? 64'(-dnum) : dnum[63:0];
  assign dreq.den   = den_r[63:0];

  logic [31:0] dval;
  always_comb begin
    if (drsp.ovf) dval = dneg ? 32'h80000000 : 32'h7fffffff;
    else if (dneg) dval = (drsp.quo[31]) ? 32'h80000000 : 32'(-drsp.quo);
    else dval = drsp.quo[31] ? 32'h7fffffff : drsp.quo;
  end

  logic full, empty, two;
  assign full  = (cnt_r >= crpn_pkg::CNT_W'(crpn_pkg::STACK_DEPTH));
  assign empty = (cnt_r == '0);
  assign two   = (cnt_r >= crpn_pkg::CNT_W'(2));

  function automatic logic [1:0] rec(input logic [1:0] e, input logic [1:0] c);
    return (e == 2'd0) ? c : e;
  endfunction

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      err_r   <= '0;
      zr_r    <= '0;
      zi_r    <= '0;
      o_v_r   <= 1'b0;
      mstep_r <= '0;
      dsel_r  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == crpn_pkg::REG_Z_REAL) zr_r <= cfg.data;
        else zi_r <= cfg.data;
      end
      if (o_v_r && res.ready && state_r != S_OUT) o_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (tok.valid && tok.ready) begin
          op_r   <= crpn_pkg::op_t'(tok.operation);
          cr_r   <= tok.const_real;
          ci_r   <= tok.const_imag;
          last_r <= tok.last_token;
          state_r <= S_READ;
        end
        S_READ: state_r <= S_EXEC; // memory read latency
        S_EXEC: begin
          state_r <= S_FIN;
          unique case (op_r)
            crpn_pkg::OP_PUSHC, crpn_pkg::OP_PUSHZ, crpn_pkg::OP_DUP: begin
              if (op_r == crpn_pkg::OP_DUP && empty) err_r <= rec(err_r, crpn_pkg::ST_UNDER);
              else if (full) err_r <= rec(err_r, crpn_pkg::ST_OVER);
              else begin
                wr_addr_r <= crpn_pkg::PTR_W'(cnt_r);
                wr_data_r <= (op_r == crpn_pkg::OP_PUSHC) ? {cr_r, ci_r} :
                             (op_r == crpn_pkg::OP_PUSHZ) ? {zr_r, zi_r} : rd_b_r;
                cnt_r <= cnt_r + 1'b1;
                state_r <= S_WRITE;
              end
            end
            crpn_pkg::OP_DROP: begin
              if (empty) err_r <= rec(err_r, crpn_pkg::ST_UNDER);
              else cnt_r <= cnt_r - 1'b1;
            end
            crpn_pkg::OP_CONJ, crpn_pkg::OP_NEG: begin
              if (empty) err_r <= rec(err_r, crpn_pkg::ST_UNDER);
              else begin
                wr_addr_r <= top_idx;
                wr_data_r <= {(op_r == crpn_pkg::OP_NEG) ? negsat(rd_b_r[63:32])
                              : rd_b_r[63:32], negsat(rd_b_r[31:0])};
                state_r <= S_WRITE;
              end
            end
            crpn_pkg::OP_ADD, crpn_pkg::OP_SUB, crpn_pkg::OP_MUL, crpn_pkg::OP_DIV: begin
              if (!two) err_r <= rec(err_r, crpn_pkg::ST_UNDER);
              else begin
                wr_addr_r <= crpn_pkg::PTR_W'(cnt_r - 2'd2);
                cnt_r <= cnt_r - 1'b1;
                if (op_r == crpn_pkg::OP_ADD) begin
                  wr_data_r <= {sat65(65'($signed(rd_a_r[63:32])) + 65'($signed(rd_b_r[63:32]))),
                                sat65(65'($signed(rd_a_r[31:0])) + 65'($signed(rd_b_r[31:0])))};
                  state_r <= S_WRITE;
                end else if (op_r == crpn_pkg::OP_SUB) begin
                  wr_data_r <= {sat65(65'($signed(rd_a_r[63:32])) - 65'($signed(rd_b_r[63:32]))),
                                sat65(65'($signed(rd_a_r[31:0])) - 65'($signed(rd_b_r[31:0])))};
                  state_r <= S_WRITE;
                end else begin
                  mstep_r <= '0;
                  acc0_r <= '0; acc1_r <= '0; den_r <= '0;
                  state_r <= S_MUL;
                end
              end
            end
            default: ;
          endcase
        end
        // One product per cycle, registered, then accumulated.
        S_MUL: begin
          p_r <= ma * mb;
          mstep_r <= mstep_r + 1'b1;
          if (mstep_r != 3'd0) begin
            unique case (mstep_r - 1'b1)
              3'd0: acc0_r <= acc0_r + 65'(p_r);
              3'd1: acc0_r <= (op_r == crpn_pkg::OP_MUL) ? acc0_r - 65'(p_r)
                                                          : acc0_r + 65'(p_r);
              3'd2: acc1_r <= (op_r == crpn_pkg::OP_MUL) ? acc1_r + 65'(p_r)
                                                          : acc1_r - 65'(p_r);
              3'd3: acc1_r <= acc1_r + 65'(p_r);
              3'd4: den_r <= den_r + 65'(p_r);
              3'd5: den_r <= den_r + 65'(p_r);
              default: ;
            endcase
          end
          if ((op_r == crpn_pkg::OP_MUL && mstep_r == 3'd4) || mstep_r == 3'd6) begin
            if (op_r == crpn_pkg::OP_MUL) begin
              state_r <= S_WRITE;
              wr_data_r <= {mulfix(acc0_r), mulfix(acc1_r + 65'(p_r))};
            end else begin
              dsel_r <= 1'b0;
              if (den_r + 65'(p_r) == '0) begin
                err_r <= rec(err_r, crpn_pkg::ST_DIVZ);
                wr_data_r <= '0;
                state_r <= S_WRITE;
              end else begin
                state_r <= S_DIVS;
              end
            end
          end
        end
        S_DIVS: state_r <= S_DIVW;
        S_DIVW: if (drsp.done) begin
          if (!dsel_r) begin
            res_re_r <= dval;
            dsel_r <= 1'b1;
            state_r <= S_DIVS;
          end else begin
            wr_data_r <= {res_re_r, dval};
            state_r <= S_WRITE;
          end
        end
        S_WRITE: state_r <= S_FIN;
        S_FIN: state_r <= last_r ? S_RDTOP : S_IDLE;
        S_RDTOP: state_r <= S_OUT; // top row read after the last write
        // The result register takes a new result once the previous one has gone.
        S_OUT: begin
          if (!o_v_r || res.ready) begin
            if (empty) begin
              o_re_r <= '0; o_im_r <= '0;
              o_st_r <= rec(err_r, crpn_pkg::ST_UNDER);
            end else begin
              o_re_r <= rd_b_r[63:32]; o_im_r <= rd_b_r[31:0];
              o_st_r <= err_r;
            end
            o_v_r <= 1'b1;
            cnt_r <= '0;
            err_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/complex_rpn_stack_evaluator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_rpn_stack_evaluator: complex RPN evaluator, top level
// Channel  Dir  Payload
// tok      in   operation, const_real, const_imag, last_token
// res      out  value_real, value_imag, status
// cfg      in   index, data (z_real, z_imag)
// Drop, unknown and underflowing or overflowing tokens skip the write step;
// other tokens take it. Multiply runs on the shared 32x32 multiplier; divide
// also uses the divider, one quotient bit a cycle over 80 steps for each of
// two components, unless the divisor is zero. A last token reads the top row
// and waits in its final step while an earlier result is still held.
// Reset is synchronous; the stack holds no reset value.
// ----------------------------------------------------------------------------
module complex_rpn_stack_evaluator (
  input logic        clk,
  input logic        rst_n,
  crpn_tok_if.sink   in_tok,
  crpn_res_if.source out_res,
  crpn_cfg_if.sink   cfg_wr
);

  crpn_pkg::div_req_t dreq;
  crpn_pkg::div_rsp_t drsp;

  crpn_core u_core (
    .clk(clk), .rst_n(rst_n), .tok(in_tok), .res(out_res), .cfg(cfg_wr),
    .dreq(dreq), .drsp(drsp)
  );

  crpn_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

endmodule

/* hdl/crpn_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpn_checker: port-level checks
// Observes the top level's token and result channels over time.
// ----------------------------------------------------------------------------
module crpn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        tv, tr, rv, rr,
  input logic [65:0] rd
);
  // A result stays offered until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n) rv && !rr |=> rv)
    else $error("result dropped");
  // A waiting result keeps its payload.
  a_data: assert property (@(posedge clk) disable iff (!rst_n) rv && !rr |=> $stable(rd))
    else $error("result payload changed while waiting");
  // A token is not taken in the cycle after another.
  a_seq: assert property (@(posedge clk) disable iff (!rst_n) tv && tr |=> !tr)
    else $error("back to back token");
  // Reset clears any offered result.
  a_reset: assert property (@(posedge clk) !rst_n |=> !rv)
    else $error("result offered after reset");
endmodule

bind complex_rpn_stack_evaluator crpn_checker u_chk (
  .clk(clk), .rst_n(rst_n), .tv(in_tok.valid), .tr(in_tok.ready),
  .rv(out_res.valid), .rr(out_res.ready),
  .rd({out_res.value_real, out_res.value_imag, out_res.status})
);
